/* design/grey_level_contrast_remap_assert.svh */
// ----------------------------------------------------------------------------
// grey_level_contrast_remap assertion macros
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GREY_LEVEL_CONTRAST_REMAP_ASSERT_SVH
`define GREY_LEVEL_CONTRAST_REMAP_ASSERT_SVH

`ifndef SYNTHESIS
`define GLCR_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define GLCR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GLCR_ASSERT(label, ante, cons, msg)
`define GLCR_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

/* design/glcr_pkg.sv */
// ----------------------------------------------------------------------------
// glcr_pkg
// Shared types and constants of the grey level contrast remap pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package glcr_pkg;

    localparam int PIX_W     = 8;
    localparam int QUO_W     = 9;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_GREY_LOW  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GREY_HIGH = CFG_IDX_W'(1);

    typedef logic [PIX_W-1:0] pix_t;

    typedef struct packed {
        pix_t pix;
        logic pass;
        logic zero;
        logic neg;
        pix_t divisor;
    } ctl_t;

    typedef struct packed {
        pix_t             rem;
        logic [QUO_W-1:0] low;
        logic [QUO_W-1:0] quo;
        logic             ovf;
    } div_t;

endpackage

`default_nettype wire

/* design/grey_level_contrast_remap.sv */
// ----------------------------------------------------------------------------
// grey_level_contrast_remap
// Piecewise-linear contrast stretch of 8-bit grey pixels, six-stage pipeline.
// ----------------------------------------------------------------------------
// channel   signals                          request
// input     in_valid, in_stall, pixel_in     one grey pixel
// output    out_valid, out_stall, pixel_out  one remapped pixel
// config    cfg_write, cfg_index, cfg_data   register write, no wait
//
// One pixel per clock while in_stall is low; stages are setup, multiply, three divider
// stages of three quotient bits each, and clamp.
// rst_n clears the valid bits and sets grey_low to 0, grey_high to 255.
// out_stall holds only the stages behind the output with no bubble ahead.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "grey_level_contrast_remap_assert.svh"

module grey_level_contrast_remap
    import glcr_pkg::*;
#(
    parameter int PIXEL_MAX = 255
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire pix_t                 pixel_in,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output pix_t                      pixel_out,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire pix_t                 cfg_data
);

    localparam int PM_BITS   = $clog2(PIXEL_MAX + 1);
    localparam int FACT_W    = (PM_BITS > QUO_W) ? PM_BITS : QUO_W;
    localparam int PROD_W    = PIX_W + FACT_W;
    localparam int DEPTH     = 6;
    localparam int DIV_STEPS = QUO_W / 3;
    localparam logic [PIX_W-1:0] PIX_TOP = (PIXEL_MAX < 255) ? PIX_W'(PIXEL_MAX) : '1;

    pix_t                grey_low_reg;
    pix_t                grey_high_reg;
    logic [DEPTH-1:0]    valid_reg;
    logic [DEPTH-1:0]    valid_next;
    logic [DEPTH-1:0]    en;

    ctl_t                s1_ctl;
    pix_t                s1_span;
    logic [FACT_W-1:0]   s1_fact;
    ctl_t                s2_ctl;
    logic [PROD_W-1:0]   s2_prod;
    div_t                d0_div;
    ctl_t                d1_ctl;
    div_t                d1_div;
    ctl_t                d2_ctl;
    div_t                d2_div;
    ctl_t                d3_ctl;
    div_t                d3_div;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grey_low_reg  <= '0;
            grey_high_reg <= '1;
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_GREY_LOW)
                grey_low_reg <= cfg_data;
            if (cfg_index == REG_GREY_HIGH)
                grey_high_reg <= cfg_data;
        end
    end

    always_comb
    begin
        en[DEPTH-1] = !valid_reg[DEPTH-1] || !out_stall;
        for (int i = DEPTH - 2; i >= 0; i--)
            en[i] = !valid_reg[i] || en[i+1];
        valid_next = {valid_reg[DEPTH-2:0], in_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= (en & valid_next) | (~en & valid_reg);
    end

    assign in_stall  = !en[0];
    assign out_valid = valid_reg[DEPTH-1];

    glcr_setup #(
        .PIXEL_MAX (PIXEL_MAX),
        .FACT_W    (FACT_W)
    ) u_setup (
        .clk       (clk),
        .en        (en[0]),
        .pixel     (pixel_in),
        .grey_low  (grey_low_reg),
        .grey_high (grey_high_reg),
        .ctl       (s1_ctl),
        .span      (s1_span),
        .fact      (s1_fact)
    );

    glcr_mult #(
        .FACT_W (FACT_W),
        .PROD_W (PROD_W)
    ) u_mult (
        .clk     (clk),
        .en      (en[1]),
        .src_ctl (s1_ctl),
        .span    (s1_span),
        .fact    (s1_fact),
        .ctl     (s2_ctl),
        .prod    (s2_prod)
    );

    // quotient beyond QUO_W bits only saturates, so flag it and divide the rest
    always_comb
    begin
        d0_div.ovf = (s2_prod[PROD_W-1:QUO_W] >= (PROD_W-QUO_W)'(s2_ctl.divisor));
        d0_div.rem = s2_prod[QUO_W+PIX_W-1:QUO_W];
        d0_div.low = s2_prod[QUO_W-1:0];
        d0_div.quo = '0;
    end

    glcr_div #(
        .STEPS (DIV_STEPS)
    ) u_div1 (
        .clk     (clk),
        .en      (en[2]),
        .src_ctl (s2_ctl),
        .src_div (d0_div),
        .ctl     (d1_ctl),
        .div     (d1_div)
    );

    glcr_div #(
        .STEPS (DIV_STEPS)
    ) u_div2 (
        .clk     (clk),
        .en      (en[3]),
        .src_ctl (d1_ctl),
        .src_div (d1_div),
        .ctl     (d2_ctl),
        .div     (d2_div)
    );

    glcr_div #(
        .STEPS (QUO_W - 2 * DIV_STEPS)
    ) u_div3 (
        .clk     (clk),
        .en      (en[4]),
        .src_ctl (d2_ctl),
        .src_div (d2_div),
        .ctl     (d3_ctl),
        .div     (d3_div)
    );

    glcr_sat #(
        .PIX_TOP (PIX_TOP)
    ) u_sat (
        .clk     (clk),
        .en      (en[5]),
        .src_ctl (d3_ctl),
        .src_div (d3_div),
        .pixel   (pixel_out)
    );

    `GLCR_ASSERT(a_stall_only_when_full, in_stall, &valid_reg, "input stalled with a bubble in the pipeline")
    `GLCR_ASSERT(a_divisor_nonzero, valid_reg[0] && !s1_ctl.pass && !s1_ctl.zero, s1_ctl.divisor != '0, "zero divisor on a live item")
    `GLCR_ASSERT_NEXT(a_pass_through, en[5] && valid_reg[4] && d3_ctl.pass, pixel_out == $past(d3_ctl.pix), "inverted window did not pass the pixel")

endmodule

`default_nettype wire

/* design/glcr_setup.sv */
// ----------------------------------------------------------------------------
// glcr_setup
// Midpoint, branch choice, distance, scale factor and divisor per pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module glcr_setup
    import glcr_pkg::*;
#(
    parameter int PIXEL_MAX = 255,
    parameter int FACT_W    = 9
)
(
    input  wire logic              clk,
    input  wire logic              en,
    input  wire pix_t              pixel,
    input  wire pix_t              grey_low,
    input  wire pix_t              grey_high,
    output ctl_t                   ctl,
    output pix_t                   span,
    output logic [FACT_W-1:0]      fact
);

    localparam logic [FACT_W-1:0] PM_V = FACT_W'(PIXEL_MAX);

    logic [PIX_W:0]      sum;
    pix_t                mid;
    logic                upper;
    logic [FACT_W-1:0]   hi_f;
    ctl_t                ctl_next;
    ctl_t                ctl_reg;
    pix_t                span_next;
    pix_t                span_reg;
    logic [FACT_W-1:0]   fact_next;
    logic [FACT_W-1:0]   fact_reg;

    always_comb
    begin
        sum   = {1'b0, grey_low} + {1'b0, grey_high};
        mid   = sum[PIX_W:1];
        upper = (pixel >= mid);
        hi_f  = FACT_W'(grey_high);

        ctl_next.pix  = pixel;
        ctl_next.pass = (grey_low >= grey_high);
        ctl_next.zero = !upper && (mid == grey_low);
        if (upper)
        begin
            span_next        = pixel - mid;
            ctl_next.neg     = (PM_V < hi_f);
            fact_next        = (PM_V < hi_f) ? (hi_f - PM_V) : (PM_V - hi_f);
            ctl_next.divisor = grey_high - mid;
        end
        else
        begin
            span_next        = mid - pixel;
            ctl_next.neg     = 1'b1;
            fact_next        = FACT_W'(grey_low);
            ctl_next.divisor = mid - grey_low;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_reg  <= ctl_next;
            span_reg <= span_next;
            fact_reg <= fact_next;
        end
    end

    assign ctl  = ctl_reg;
    assign span = span_reg;
    assign fact = fact_reg;

endmodule

`default_nettype wire

/* design/glcr_mult.sv */
// ----------------------------------------------------------------------------
// glcr_mult
// Distance times scale factor, registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module glcr_mult
    import glcr_pkg::*;
#(
    parameter int FACT_W = 9,
    parameter int PROD_W = 17
)
(
    input  wire logic              clk,
    input  wire logic              en,
    input  wire ctl_t              src_ctl,
    input  wire pix_t              span,
    input  wire logic [FACT_W-1:0] fact,
    output ctl_t                   ctl,
    output logic [PROD_W-1:0]      prod
);

    ctl_t                ctl_reg;
    logic [PROD_W-1:0]   prod_next;
    logic [PROD_W-1:0]   prod_reg;

    always_comb
    begin
        prod_next = PROD_W'(span) * PROD_W'(fact);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_reg  <= src_ctl;
            prod_reg <= prod_next;
        end
    end

    assign ctl  = ctl_reg;
    assign prod = prod_reg;

endmodule

`default_nettype wire

/* design/glcr_div.sv */
// ----------------------------------------------------------------------------
// glcr_div
// STEPS restoring division steps, one quotient bit each, registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module glcr_div
    import glcr_pkg::*;
#(
    parameter int STEPS = 3
)
(
    input  wire logic clk,
    input  wire logic en,
    input  wire ctl_t src_ctl,
    input  wire div_t src_div,
    output ctl_t      ctl,
    output div_t      div
);

    ctl_t           ctl_reg;
    div_t           div_next;
    div_t           div_reg;
    logic [PIX_W:0] r9;
    logic [PIX_W:0] dv;

    always_comb
    begin
        div_next = src_div;
        dv       = {1'b0, src_ctl.divisor};
        r9       = '0;
        for (int i = 0; i < STEPS; i++)
        begin
            r9 = {div_next.rem, div_next.low[QUO_W-1]};
            if (r9 >= dv)
            begin
                div_next.rem = PIX_W'(r9 - dv);
                div_next.quo = {div_next.quo[QUO_W-2:0], 1'b1};
            end
            else
            begin
                div_next.rem = r9[PIX_W-1:0];
                div_next.quo = {div_next.quo[QUO_W-2:0], 1'b0};
            end
            div_next.low = {div_next.low[QUO_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_reg <= src_ctl;
            div_reg <= div_next;
        end
    end

    assign ctl = ctl_reg;
    assign div = div_reg;

endmodule

`default_nettype wire

/* design/glcr_sat.sv */
// ----------------------------------------------------------------------------
// glcr_sat
// Applies the signed offset to the pixel and clamps to the output range, or passes the pixel or gives zero per flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module glcr_sat
    import glcr_pkg::*;
#(
    parameter logic [7:0] PIX_TOP = 8'hFF
)
(
    input  wire logic clk,
    input  wire logic en,
    input  wire ctl_t src_ctl,
    input  wire div_t src_div,
    output pix_t      pixel
);

    logic [QUO_W-1:0]        quo;
    logic signed [QUO_W+1:0] pix_s;
    logic signed [QUO_W+1:0] quo_s;
    logic signed [QUO_W+1:0] val;
    pix_t                    pixel_next;
    pix_t                    pixel_reg;

    always_comb
    begin
        quo   = src_div.ovf ? '1 : src_div.quo;
        pix_s = $signed((QUO_W+2)'(src_ctl.pix));
        quo_s = $signed((QUO_W+2)'(quo));
        val   = src_ctl.neg ? (pix_s - quo_s) : (pix_s + quo_s);
        priority if (src_ctl.pass)
            pixel_next = src_ctl.pix;
        else if (src_ctl.zero)
            pixel_next = '0;
        else if (val < 0)
            pixel_next = '0;
        else if (val > $signed((QUO_W+2)'(PIX_TOP)))
            pixel_next = PIX_TOP;
        else
            pixel_next = val[PIX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pixel_reg <= pixel_next;
        end
    end

    assign pixel = pixel_reg;

endmodule

`default_nettype wire
